### rtl/core/relay_duplicate_filter_unit_macros.svh
// Assertion macros used by the checker file of the relay duplicate filter.
`ifndef RELAY_DUPLICATE_FILTER_UNIT_MACROS_SVH
`define RELAY_DUPLICATE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdf assertion failed");

`endif

### rtl/core/rdf_pkg.sv
// Package with types and constants of the relay duplicate filter.
package rdf_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int SEQ_BITS   = 31;
  localparam int ID_BITS    = 8;
  localparam int CFG_BITS   = 8;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_BACK  = 2'd2;
  localparam logic [1:0] SIDE_BOTH  = 2'd3;

  typedef enum logic [2:0] {
    STAT_RELAYED   = 3'd0,
    STAT_OWN_ECHO  = 3'd1,
    STAT_BOTH_ERR  = 3'd2,
    STAT_END_NODE  = 3'd3,
    STAT_DUPLICATE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_OWN_ID    = 2'd0,
    CFG_IS_LEADER = 2'd1,
    CFG_IS_LAST   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_EVAL = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]  sender_id;
    logic [SEQ_BITS-1:0] seq_number;
    logic [1:0]          rx_interface;
  } beacon_t;

  typedef struct packed {
    logic       relay;
    logic [1:0] tx_interface;
    status_e    status;
  } verdict_t;

  typedef struct packed {
    logic capture;
    logic evaluate;
  } ctrl_cmd_t;

endpackage

### rtl/core/relay_duplicate_filter_unit.sv
// Top level of the relay duplicate filter: one beacon in, one verdict out.
// A beacon is accepted in the idle state, with a registered read of the sequence table;
// the compare-and-write step then registers the verdict, marked by result_valid_o. No new
// beacon is accepted while busy is high during that step.
// Reset clears the configuration, the controller and the seen flags of all senders at
// once; the sequence table itself is not cleared and there is no clearing pass.
module relay_duplicate_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rdf_pkg::beacon_t               beacon_i,
  output logic                           result_valid_o,
  output rdf_pkg::verdict_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [rdf_pkg::CFG_BITS-1:0]   cfg_data_i
);
  import rdf_pkg::*;

  // The controller issues a capture when a beacon is accepted and an evaluate in the
  // cycle after, once the stored sequence number of that sender has been read.
  ctrl_cmd_t cmd;

  rdf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // The datapath holds the configuration registers, the per-sender seen flags, the
  // sequence table and the output register. The result register frees the controller
  // to take the next item in the same cycle the previous verdict is shown.
  rdf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .beacon_i       (beacon_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### rtl/core/rdf_ctrl.sv
// Controller state machine of the relay duplicate filter.
module rdf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output rdf_pkg::ctrl_cmd_t cmd_o
);
  import rdf_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.evaluate = 1'b0;
    busy           = 1'b0;
    case (state_q)
      STATE_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = STATE_EVAL;
        end
      end
      STATE_EVAL: begin
        busy           = 1'b1;
        cmd_o.evaluate = 1'b1;
        state_d        = STATE_IDLE;
      end
      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/rdf_dp.sv
// Datapath of the relay duplicate filter: configuration, sender table, decision.
module rdf_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rdf_pkg::ctrl_cmd_t             cmd_i,
  input  rdf_pkg::beacon_t               beacon_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [rdf_pkg::CFG_BITS-1:0]   cfg_data_i,
  output logic                           result_valid_o,
  output rdf_pkg::verdict_t              result_o
);
  import rdf_pkg::*;

  logic [ID_BITS-1:0]    own_id_q;
  logic                  is_leader_q;
  logic                  is_last_q;
  logic [NODE_COUNT-1:0] seen_q;
  logic                  valid_q;

  beacon_t               beacon_q;
  logic [SEQ_BITS-1:0]   rd_seq_q;
  verdict_t              result_q;
  logic [SEQ_BITS-1:0]   seq_mem [NODE_COUNT];

  logic [NODE_BITS-1:0]  rd_slot;
  logic [NODE_BITS-1:0]  slot;
  logic                  own_echo;
  logic                  both_err;
  logic                  end_node;
  logic                  duplicate;
  logic                  do_relay;
  logic [1:0]            tx_side;
  verdict_t              verdict;

  assign rd_slot = NODE_BITS'(beacon_i.sender_id % NODE_COUNT);
  assign slot    = NODE_BITS'(beacon_q.sender_id % NODE_COUNT);

  // Decision on the captured beacon, checks in priority order.
  always_comb begin
    own_echo  = (beacon_q.sender_id == own_id_q);
    both_err  = (beacon_q.rx_interface == SIDE_BOTH);
    end_node  = is_leader_q | is_last_q;
    duplicate = seen_q[slot] && !(beacon_q.seq_number > rd_seq_q);
    do_relay  = !own_echo && !both_err && !end_node && !duplicate;
    case (beacon_q.rx_interface)
      SIDE_FRONT: tx_side = SIDE_BACK;
      SIDE_BACK:  tx_side = SIDE_FRONT;
      default:    tx_side = SIDE_BOTH;
    endcase
    verdict.relay        = do_relay;
    verdict.tx_interface = do_relay ? tx_side : SIDE_NONE;
    if (own_echo) begin
      verdict.status = STAT_OWN_ECHO;
    end else if (both_err) begin
      verdict.status = STAT_BOTH_ERR;
    end else if (end_node) begin
      verdict.status = STAT_END_NODE;
    end else if (duplicate) begin
      verdict.status = STAT_DUPLICATE;
    end else begin
      verdict.status = STAT_RELAYED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      is_leader_q <= 1'b0;
      is_last_q   <= 1'b0;
      seen_q      <= '0;
      valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_OWN_ID:    own_id_q    <= cfg_data_i[ID_BITS-1:0];
          CFG_IS_LEADER: is_leader_q <= cfg_data_i[0];
          CFG_IS_LAST:   is_last_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      valid_q <= cmd_i.evaluate;
      if (cmd_i.evaluate && do_relay) begin
        seen_q[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      beacon_q <= beacon_i;
      rd_seq_q <= seq_mem[rd_slot];
    end
    if (cmd_i.evaluate) begin
      result_q <= verdict;
      if (do_relay) begin
        seq_mem[slot] <= beacon_q.seq_number;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

### rtl/core/rdf_checker.sv
// Port-level checker of the relay duplicate filter, bound to the top level.
`include "relay_duplicate_filter_unit_macros.svh"

module rdf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input rdf_pkg::verdict_t result_o
);
  import rdf_pkg::*;

  logic accept;
  logic relay_shown;
  logic relay_ok;
  logic hold_shown;
  logic hold_ok;

  assign accept      = start && !busy;
  assign relay_shown = result_valid_o && result_o.relay;
  assign relay_ok    = (result_o.status == STAT_RELAYED) && (result_o.tx_interface != SIDE_NONE);
  assign hold_shown  = result_valid_o && !result_o.relay;
  assign hold_ok     = (result_o.status != STAT_RELAYED) && (result_o.tx_interface == SIDE_NONE);

  `RDF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, busy)
  `RDF_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, busy, result_valid_o && !busy)
  `RDF_ASSERT_SAME(a_relay_status, clk_i, rst_ni, relay_shown, relay_ok)
  `RDF_ASSERT_SAME(a_no_relay_no_side, clk_i, rst_ni, hold_shown, hold_ok)

endmodule

bind relay_duplicate_filter_unit rdf_checker u_rdf_checker (.*);
